// File: src/scl_pkg.sv
// ----------------------------------------------------------------------------
// scl_pkg
// Shared types and constants of the split cache tag lookup unit.
// ----------------------------------------------------------------------------
package scl_pkg;

  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned TAG_LSB   = 12;
  localparam int unsigned TAG_W     = ADDR_W - TAG_LSB;
  localparam int unsigned SET_W     = 9;
  localparam int unsigned ROW_W     = SET_W + 1;
  localparam int unsigned ROWS      = 1 << ROW_W;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 1;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LARGE_CACHE = 2'd0,
    CFG_LONG_LINE   = 2'd1,
    CFG_TWO_WAY     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic large_cache;
    logic long_line;
    logic two_way;
  } cfg_t;

  typedef struct packed {
    logic             active;
    logic [ROW_W-1:0] row;
  } clr_t;

  // One memory row holds both ways of a set and its replacement mark.
  typedef struct packed {
    logic [TAG_W-1:0] tag1;
    logic [TAG_W-1:0] tag0;
    logic             valid1;
    logic             valid0;
    logic             lru;
  } row_data_t;

endpackage

// File: src/scl_cfg_clear.sv
// ----------------------------------------------------------------------------
// scl_cfg_clear
// Geometry registers and the sweep that clears the tag memory.
// ----------------------------------------------------------------------------
module scl_cfg_clear
  import scl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output cfg_t                 cfg_o,
  output clr_t                 clr_o
);

  cfg_t             cfg_q, cfg_d;
  logic             active_q, active_d;
  logic [ROW_W-1:0] cnt_q, cnt_d;
  logic             hit_reg;

  always_comb begin
    cfg_d   = cfg_q;
    hit_reg = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LARGE_CACHE: begin
          cfg_d.large_cache = cfg_data_i[0];
          hit_reg = 1'b1;
        end
        CFG_LONG_LINE: begin
          cfg_d.long_line = cfg_data_i[0];
          hit_reg = 1'b1;
        end
        CFG_TWO_WAY: begin
          cfg_d.two_way = cfg_data_i[0];
          hit_reg = 1'b1;
        end
        default: hit_reg = 1'b0;
      endcase
    end
  end

  // Any write to a defined register restarts the sweep from row zero.
  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    if (hit_reg) begin
      active_d = 1'b1;
      cnt_d    = '0;
    end else if (active_q) begin
      cnt_d = cnt_q + ROW_W'(1);
      if (cnt_q == ROW_LAST) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q    <= '{large_cache: 1'b0, long_line: 1'b1, two_way: 1'b0};
      active_q <= 1'b1;
      cnt_q    <= '0;
    end else begin
      cfg_q    <= cfg_d;
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  assign cfg_o        = cfg_q;
  assign clr_o.active = active_q;
  assign clr_o.row    = cnt_q;

endmodule

// File: src/scl_addr_split.sv
// ----------------------------------------------------------------------------
// scl_addr_split
// Splits a byte address into memory row and tag for the current geometry.
// ----------------------------------------------------------------------------
module scl_addr_split
  import scl_pkg::*;
(
  input  cfg_t              cfg_i,
  input  logic [ADDR_W-1:0] address_i,
  input  logic              cache_select_i,
  output logic [ROW_W-1:0]  row_o,
  output logic [TAG_W-1:0]  tag_o
);

  logic [3:0]       set_bits;
  logic [SET_W-1:0] set_mask;
  logic [SET_W-1:0] set_raw;
  logic [1:0]       tag_shift;

  // Set bits are capacity bits minus line bits minus one for two ways.
  always_comb begin
    set_bits = 4'd7 + {2'b00, cfg_i.large_cache, 1'b0}
             - {3'b000, cfg_i.long_line} - {3'b000, cfg_i.two_way};
    set_mask = {SET_W{1'b1}} >> (4'(SET_W) - set_bits);
    set_raw  = cfg_i.long_line ? address_i[7 +: SET_W] : address_i[6 +: SET_W];
    // The tag starts at bit 12, 13, 14 or 15.
    tag_shift = {cfg_i.large_cache, ~cfg_i.two_way};
    tag_o     = address_i[ADDR_W-1:TAG_LSB] >> tag_shift;
    row_o     = {cache_select_i, set_raw & set_mask};
  end

endmodule

// File: src/scl_tag_ram.sv
// ----------------------------------------------------------------------------
// scl_tag_ram
// Tag memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module scl_tag_ram
  import scl_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [ROW_W-1:0] waddr_i,
  input  row_data_t        wdata_i,
  input  logic [ROW_W-1:0] raddr_i,
  output row_data_t        rdata_o
);

  row_data_t mem_q [ROWS];
  row_data_t rdata_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/scl_way_select.sv
// ----------------------------------------------------------------------------
// scl_way_select
// Tag compare, victim choice and updated row for one lookup.
// ----------------------------------------------------------------------------
module scl_way_select
  import scl_pkg::*;
(
  input  cfg_t             cfg_i,
  input  row_data_t        row_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             hit_o,
  output row_data_t        row_o
);

  logic eq0, eq1, h0, h1, way;

  always_comb begin
    eq0   = row_i.tag0 == tag_i;
    eq1   = row_i.tag1 == tag_i;
    h0    = row_i.valid0 && eq0;
    h1    = row_i.valid1 && eq1;
    row_o = row_i;
    way   = 1'b0;
    hit_o = 1'b0;
    if (!cfg_i.two_way) begin
      // Direct mapped: way 0 only, and a cleared tag of zero counts as present.
      hit_o = eq0;
      if (!eq0) begin
        row_o.tag0   = tag_i;
        row_o.valid0 = 1'b1;
      end
    end else begin
      priority if (h0) begin
        hit_o = 1'b1;
        way   = 1'b0;
      end else if (h1) begin
        hit_o = 1'b1;
        way   = 1'b1;
      end else if (!row_i.valid0) begin
        way = 1'b0;
      end else if (!row_i.valid1) begin
        way = 1'b1;
      end else begin
        way = row_i.lru;
      end
      if (!hit_o) begin
        if (way) begin
          row_o.tag1   = tag_i;
          row_o.valid1 = 1'b1;
        end else begin
          row_o.tag0   = tag_i;
          row_o.valid0 = 1'b1;
        end
      end
      row_o.lru = ~way;
    end
  end

endmodule

// File: src/split_cache_tag_lookup_unit.sv
// ----------------------------------------------------------------------------
// split_cache_tag_lookup_unit
// Hit/miss lookup for split instruction and data cache tag stores.
// ----------------------------------------------------------------------------
// The unit accepts one access per cycle while in_stall_o is low, and presents
// its hit flag from a result register: the tag memory row is read at the
// transfer edge, and the compare and write-back of that row follow in the
// lookup stage, which ends by loading the result register. The tag memory has
// a single read and a single write port, so a back-to-back access to the row
// just updated takes the written data from a forwarding register. After reset
// and after every write to a defined configuration register, the whole tag
// memory is swept clear, one row per cycle over all 1024 rows, and no access is
// taken during that sweep. A result that waits on the output side holds the
// lookup stage, and then the input side as well.
module split_cache_tag_lookup_unit
  import scl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ADDR_W-1:0]    address_i,
  input  logic                 cache_select_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 hit_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  cfg_t             cfg;
  clr_t             clr;
  logic [ROW_W-1:0] new_row;
  logic [TAG_W-1:0] new_tag;
  logic             in_accept;
  logic             s1_done;

  logic             s1_valid_q, s1_valid_d;
  logic [ROW_W-1:0] s1_row_q;
  logic [TAG_W-1:0] s1_tag_q;
  logic             out_valid_q, out_valid_d;
  logic             hit_q;
  logic             fwd_valid_q, fwd_valid_d;
  logic [ROW_W-1:0] fwd_row_q;
  row_data_t        fwd_data_q;

  logic             ram_we;
  logic [ROW_W-1:0] ram_waddr;
  row_data_t        ram_wdata;
  logic [ROW_W-1:0] ram_raddr;
  row_data_t        ram_rdata;
  row_data_t        cur_row;
  row_data_t        upd_row;
  logic             lookup_hit;

  scl_cfg_clear u_cfg_clear (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .clr_o       (clr)
  );

  scl_addr_split u_addr_split (
    .cfg_i          (cfg),
    .address_i      (address_i),
    .cache_select_i (cache_select_i),
    .row_o          (new_row),
    .tag_o          (new_tag)
  );

  // The lookup stage finishes when the output register is free or drains now.
  assign s1_done    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clr.active || (s1_valid_q && !s1_done);
  assign in_accept  = in_valid_i && !in_stall_o;

  // A held lookup re-reads its own row, so the data stays current.
  assign ram_raddr = in_accept ? new_row : s1_row_q;

  scl_tag_ram u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The row written at the last edge is not yet in the read data.
  assign cur_row = (fwd_valid_q && (fwd_row_q == s1_row_q)) ? fwd_data_q : ram_rdata;

  scl_way_select u_way_select (
    .cfg_i (cfg),
    .row_i (cur_row),
    .tag_i (s1_tag_q),
    .hit_o (lookup_hit),
    .row_o (upd_row)
  );

  always_comb begin
    if (clr.active) begin
      ram_we    = 1'b1;
      ram_waddr = clr.row;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_done;
      ram_waddr = s1_row_q;
      ram_wdata = upd_row;
    end
  end

  always_comb begin
    s1_valid_d  = in_accept || (s1_valid_q && !s1_done);
    out_valid_d = s1_done || (out_valid_q && out_stall_i);
    fwd_valid_d = s1_done && !clr.active;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      fwd_valid_q <= fwd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_row_q <= new_row;
      s1_tag_q <= new_tag;
    end
    if (s1_done) begin
      hit_q      <= lookup_hit;
      fwd_row_q  <= s1_row_q;
      fwd_data_q <= upd_row;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;

`ifndef NO_ASSERTIONS
  a_no_accept_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) clr.active |-> in_stall_o
  ) else $error("access accepted during memory clear");

  a_accept_fills_stage : assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_accept |=> s1_valid_q
  ) else $error("accepted access did not enter the lookup stage");

  a_held_lookup_keeps_row : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && out_stall_i) |=> (s1_valid_q && $stable(s1_row_q))
  ) else $error("lookup stage lost its access while the output was held");
`endif

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the split cache tag lookup unit.
// ----------------------------------------------------------------------------
// A queue-fed driver offers accesses on the input channel, and a clocked
// monitor predicts the hit flag of every accepted access from its own copy
// of both tag stores. Each result that leaves the unit is compared in order
// with those predictions. The run walks all eight cache geometries. Both
// channels idle at random, and the receiver holds off once for a long stretch.
module tb_top;
  import scl_pkg::*;

  localparam int unsigned MAX_SETS       = 1 << SET_W;
  localparam int unsigned CAP_SMALL_W    = 13;
  localparam int unsigned CAP_BIG_W      = 15;
  localparam int unsigned LINE_SHORT_W   = 6;
  localparam int unsigned LINE_LONG_W    = 7;
  localparam int unsigned IDLE_PCT       = 21;
  localparam int unsigned CLEAR_CYCLES   = ROWS + 8;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned RAND_PER_PHASE = 179;
  localparam int unsigned HOLD_AT        = 300;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned STEADY_FROM    = 700;
  localparam int unsigned STEADY_TO      = 900;
  localparam int unsigned LIMIT_CYCLES   = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic              sel;
  } access_t;

  typedef struct {
    logic              hit;
    logic [ADDR_W-1:0] addr;
    logic              sel;
  } lookup_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic [ADDR_W-1:0]    address_i      = '0;
  logic                 cache_select_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic                 hit_o;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i    = CFG_LARGE_CACHE;
  logic [CFG_W-1:0]     cfg_data_i     = '0;

  split_cache_tag_lookup_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the tag stores and of the geometry registers.
  logic [TAG_W-1:0] tag_shadow   [2*MAX_SETS*2];
  bit               valid_shadow [2*MAX_SETS*2];
  bit               lru_shadow   [MAX_SETS];
  cfg_t             geom_q = '{large_cache: 1'b0, long_line: 1'b1, two_way: 1'b0};

  access_t     pending_q[$];
  lookup_t     expected_hits_q[$];
  logic [63:0] tag_pool[5];
  logic [63:0] set_pool[4];

  int unsigned n_in_acc  = 0;
  int unsigned n_in_sent = 0;
  int unsigned n_results = 0;
  int unsigned n_hits    = 0;
  int unsigned n_errors  = 0;
  int unsigned n_writes  = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  logic        steady;

  // One stretch of the run with no idling on either side.
  assign steady = (n_in_acc >= STEADY_FROM) && (n_in_acc < STEADY_TO);

  function automatic int unsigned line_width();
    return geom_q.long_line ? LINE_LONG_W : LINE_SHORT_W;
  endfunction

  function automatic int unsigned set_width();
    return (geom_q.large_cache ? CAP_BIG_W : CAP_SMALL_W) - line_width() - geom_q.two_way;
  endfunction

  function automatic void flush_shadow();
    foreach (tag_shadow[i]) begin
      tag_shadow[i]   = '0;
      valid_shadow[i] = 1'b0;
    end
    foreach (lru_shadow[i]) lru_shadow[i] = 1'b0;
  endfunction

  // Any write to a defined register, even one that keeps the value, rebuilds
  // both caches empty. A write to the spare index changes nothing.
  function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (cfg_idx_e'(idx))
      CFG_LARGE_CACHE: geom_q.large_cache = val[0];
      CFG_LONG_LINE:   geom_q.long_line   = val[0];
      CFG_TWO_WAY:     geom_q.two_way     = val[0];
      default:         return;
    endcase
    flush_shadow();
  endfunction

  // Predicts the hit flag of one access and updates the shadow stores.
  function automatic logic lookup_and_fill(logic [ADDR_W-1:0] addr, logic sel);
    int unsigned lw;
    int unsigned sw;
    int unsigned s;
    int unsigned base;
    int unsigned li;
    int unsigned way;
    logic [63:0] set_no;
    logic [63:0] tag_full;
    logic        hit;
    lw       = line_width();
    sw       = set_width();
    set_no   = (addr >> lw) & ((64'd1 << sw) - 64'd1);
    tag_full = addr >> (lw + sw);
    hit      = 1'b0;
    if (!geom_q.two_way) begin
      // Direct-mapped entries start at tag zero with no valid flag.
      s    = 32'(set_no & 64'(MAX_SETS - 1));
      base = (sel * MAX_SETS + s) * 2;
      if (tag_shadow[base] == tag_full[TAG_W-1:0]) begin
        hit = 1'b1;
      end else begin
        tag_shadow[base]   = tag_full[TAG_W-1:0];
        valid_shadow[base] = 1'b1;
      end
    end else begin
      s    = 32'(set_no & 64'(MAX_SETS / 2 - 1));
      li   = sel * (MAX_SETS / 2) + s;
      base = (sel * MAX_SETS + s) * 2;
      if (valid_shadow[base] && tag_shadow[base] == tag_full[TAG_W-1:0]) begin
        hit = 1'b1;
        way = 0;
      end else if (valid_shadow[base+1] && tag_shadow[base+1] == tag_full[TAG_W-1:0]) begin
        hit = 1'b1;
        way = 1;
      end else begin
        // An empty way is filled first, way 0 before way 1.
        if (!valid_shadow[base])        way = 0;
        else if (!valid_shadow[base+1]) way = 1;
        else                            way = lru_shadow[li];
        tag_shadow[base+way]   = tag_full[TAG_W-1:0];
        valid_shadow[base+way] = 1'b1;
      end
      lru_shadow[li] = (way == 0);
    end
    return hit;
  endfunction

  function automatic void queue_access(logic [ADDR_W-1:0] addr, logic sel);
    access_t acc;
    acc.addr = addr;
    acc.sel  = sel;
    pending_q.insert(pending_q.size(), acc);
  endfunction

  // Mostly accesses that reuse a few tags in a few sets, so that hits,
  // conflicts and replacement all happen; the rest is fully random.
  function automatic void queue_random_access();
    int unsigned lw;
    int unsigned sw;
    logic [63:0] a;
    lw = line_width();
    sw = set_width();
    if ($urandom_range(99, 0) < 15) begin
      a = {$urandom, $urandom};
    end else begin
      a = (tag_pool[$urandom_range(4, 0)] << (lw + sw))
        | (set_pool[$urandom_range(3, 0)] << lw)
        | ({$urandom, $urandom} & ((64'd1 << lw) - 64'd1));
    end
    queue_access(a, 1'($urandom_range(1, 0)));
  endfunction

  // Input side: a payload is held until its transfer, then the next one may
  // follow or the channel may idle.
  always @(negedge clk_i) begin
    access_t nxt;
    if (rst_ni && !(in_valid_i && n_in_acc != n_in_sent)) begin
      if (pending_q.size() != 0 && (steady || $urandom_range(99, 0) >= IDLE_PCT)) begin
        nxt = pending_q.pop_front();
        address_i      <= nxt.addr;
        cache_select_i <= nxt.sel;
        in_valid_i     <= 1'b1;
        n_in_sent++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output side: random stalls, plus one long hold-off that lets the unit
  // back up into its input.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!hold_done && n_in_acc >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !steady && ($urandom_range(99, 0) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    lookup_t want;
    if (rst_ni) begin
      if (cfg_we_i) apply_write(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) begin
        want.hit  = lookup_and_fill(address_i, cache_select_i);
        want.addr = address_i;
        want.sel  = cache_select_i;
        expected_hits_q.insert(expected_hits_q.size(), want);
        n_in_acc++;
      end
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (hit_o) n_hits++;
        if (expected_hits_q.size() == 0) begin
          $display("%0t: result transfer with no lookup pending: expected none, got hit %0b",
                   $time, hit_o);
          n_errors++;
        end else begin
          want = expected_hits_q.pop_front();
          if (hit_o !== want.hit) begin
            $display("%0t: hit mismatch, address %h cache %0d: expected %0b, got %0b",
                     $time, want.addr, want.sel, want.hit, hit_o);
            n_errors++;
          end
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic drain();
    while (pending_q.size() != 0 || in_valid_i || expected_hits_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Every defined write starts a sweep of the tag memory, so the next write
  // waits until that sweep is over.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_writes++;
    repeat (CLEAR_CYCLES) @(posedge clk_i);
  endtask

  logic [2:0] geom_list[8] = '{3'b000, 3'b111, 3'b010, 3'b101, 3'b110, 3'b001, 3'b011, 3'b100};

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset geometry, direct mapped: tag zero hits with no fill, the two
    // caches are separate, and a conflicting tag evicts the old one.
    queue_access('0, 1'b0);
    queue_access('1, 1'b0);
    queue_access('1, 1'b0);
    queue_access('1, 1'b1);
    queue_access('0, 1'b1);
    queue_access(64'h2000, 1'b0);
    queue_access('0, 1'b0);
    drain();

    // Two ways: empty ways fill in order, a hit renews its way, and the
    // least recent way is replaced.
    write_reg(CFG_TWO_WAY, 1'b1);
    queue_access(64'h0000, 1'b1);
    queue_access(64'h1000, 1'b1);
    queue_access(64'h0000, 1'b1);
    queue_access(64'h2000, 1'b1);
    queue_access(64'h0000, 1'b1);
    queue_access(64'h1000, 1'b1);
    queue_access(64'h2000, 1'b1);
    queue_access(64'h1000, 1'b1);
    queue_access('1, 1'b0);
    drain();

    // The spare index keeps the stores; rewriting the same value clears them.
    write_reg(CFG_SPARE_IDX, 1'b1);
    queue_access(64'h1000, 1'b1);
    drain();
    write_reg(CFG_TWO_WAY, 1'b1);
    queue_access(64'h1000, 1'b1);
    drain();

    foreach (geom_list[g]) begin
      write_reg(CFG_LARGE_CACHE, geom_list[g][2]);
      write_reg(CFG_LONG_LINE, geom_list[g][1]);
      write_reg(CFG_TWO_WAY, geom_list[g][0]);
      tag_pool[0] = '0;
      tag_pool[1] = 64'd1;
      tag_pool[2] = {$urandom, $urandom};
      tag_pool[3] = {$urandom, $urandom} >> $urandom_range(60, 0);
      tag_pool[4] = '1;
      set_pool[0] = '0;
      set_pool[1] = (64'd1 << set_width()) - 64'd1;
      set_pool[2] = 64'($urandom_range((1 << set_width()) - 1, 0));
      set_pool[3] = 64'($urandom_range((1 << set_width()) - 1, 0));
      repeat (RAND_PER_PHASE) queue_random_access();
      drain();
    end

    $display("Checked %0d lookups (%0d hits, %0d misses) in %0d cycles.",
             n_results, n_hits, n_results - n_hits, cycle_cnt);
    $display("Covered all eight geometries over %0d register writes, with one long output hold-off.",
             n_writes);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
src/scl_pkg.sv
src/scl_cfg_clear.sv
src/scl_addr_split.sv
src/scl_tag_ram.sv
src/scl_way_select.sv
src/split_cache_tag_lookup_unit.sv
tb/tb_top.sv
